### rtl/chm_pkg.sv
package chm_pkg;

  localparam int unsigned MaxBucketsDef = 256;
  localparam int unsigned NodePoolDef   = 512;

  typedef enum logic [1:0] {
    ActInsert = 2'd0,
    ActGet    = 2'd1,
    ActRemove = 2'd2,
    ActClear  = 2'd3
  } action_e;

  typedef struct packed {
    logic        found;
    logic [63:0] value;
    logic        pool_full;
  } res_t;

endpackage

### rtl/chm_mod.sv
module chm_mod import chm_pkg::*; #(
  parameter int unsigned BW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [63:0]   key_i,
  input  logic [BW:0]   n_i,
  output logic          done_o,
  output logic [BW-1:0] rem_o
);

  logic [BW:0]   r_q, r_d;
  logic [BW:0]   d_q;
  logic [5:0]    cnt_q;
  logic          busy_q;
  logic [BW+1:0] sh;
  logic [BW+1:0] tr;

  // one key bit per cycle: restoring remainder
  assign sh  = {r_q, key_i[6'd63 - cnt_q]};
  assign tr  = sh - {1'b0, d_q};
  assign r_d = tr[BW+1] ? sh[BW:0] : tr[BW:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q <= '0;
      d_q <= n_i;
    end else if (busy_q) begin
      r_q <= r_d;
    end
  end

  assign rem_o = r_q[BW-1:0];

endmodule

### rtl/chained_hash_map_engine.sv
// Hash map engine with separate chaining. Raise start with action, key and value while
// busy is low; one result per request follows on the result ports for a single cycle,
// marked by done_o, which the receiver must take at once. Get, insert and remove compute the
// key modulo bit-serially, read the bucket head and walk the chain (each node costs one
// node-memory read); a fresh insert also pops a node from the free list. Clear sweeps
// bucket heads and the free list one entry per cycle. After reset the block sweeps bucket
// heads and the free list with busy high.
module chained_hash_map_engine import chm_pkg::*; #(
  parameter int unsigned MAX_BUCKETS = MaxBucketsDef,
  parameter int unsigned NODE_POOL   = NodePoolDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action_i,
  input  logic [63:0] key_i,
  input  logic [63:0] value_i,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,
  output logic        done_o,
  output logic        found_o,
  output logic [63:0] result_value_o,
  output logic [9:0]  element_count_o,
  output logic        pool_full_o
);

  localparam int unsigned BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int unsigned NW = $clog2(NODE_POOL);
  localparam int unsigned SW = (MAX_BUCKETS > NODE_POOL) ? BW + 1 : NW + 1;
  localparam logic [NW:0] NIL = NW'(0) | (NW+1)'(NODE_POOL);

  typedef enum logic [3:0] {
    StInit, StIdle, StMod, StHead, StHeadW, StNode, StNodeW, StAct, StPop, StPopW,
    StClear, StOut
  } state_e;

  state_e      st_q;
  logic [8:0]  bc_q;
  logic [1:0]  act_q;
  logic [63:0] key_q, val_q;
  logic [BW-1:0] b_q;
  logic [NW:0] cur_q, prev_q, nxt_q;
  logic [NW:0] top_q;
  logic [NW:0] tot_q;
  logic [SW-1:0] sw_q;
  logic [NW:0] steps_q;
  res_t        res_q;

  // memories
  logic [NW:0]   heads_m [MAX_BUCKETS];
  logic [63:0]   keys_m  [NODE_POOL];
  logic [63:0]   vals_m  [NODE_POOL];
  logic [NW:0]   links_m [NODE_POOL];
  logic [NW-1:0] free_m  [NODE_POOL];
  logic [NW:0]   head_rd;
  logic [63:0]   key_rd, val_rd;
  logic [NW:0]   link_rd;
  logic [NW-1:0] free_rd;

  logic          hw_en, kw_en, vw_en, lw_en, fw_en;
  logic [BW-1:0] hw_a;
  logic [NW:0]   hw_d, lw_d;
  logic [NW-1:0] nw_a, lw_a, fw_a, fr_a, nr_a;
  logic [NW-1:0] fw_d;
  logic [BW-1:0] hr_a;

  // modulus
  logic [BW:0]   n_eff;
  logic          mod_start, mod_done;
  logic [BW-1:0] mod_rem;

  always_comb begin
    if (bc_q == 9'd0) n_eff = (BW+1)'(1);
    else if ({23'd0, bc_q} > MAX_BUCKETS) n_eff = (BW+1)'(MAX_BUCKETS);
    else n_eff = (BW+1)'(bc_q);
  end

  chm_mod #(.BW(BW)) u_mod (
    .clk_i, .rst_ni, .start_i(mod_start), .key_i(key_q), .n_i(n_eff),
    .done_o(mod_done), .rem_o(mod_rem)
  );

  always_ff @(posedge clk_i) begin
    if (hw_en) heads_m[hw_a] <= hw_d;
    head_rd <= heads_m[hr_a];
    if (kw_en) keys_m[nw_a] <= key_q;
    if (vw_en) vals_m[nw_a] <= val_q;
    if (lw_en) links_m[lw_a] <= lw_d;
    key_rd  <= keys_m[nr_a];
    val_rd  <= vals_m[nr_a];
    link_rd <= links_m[nr_a];
    if (fw_en) free_m[fw_a] <= fw_d;
    free_rd <= free_m[fr_a];
  end

  logic          hit;
  logic [NW-1:0] curi;
  assign curi = cur_q[NW-1:0];
  assign hit  = key_rd == key_q;
  assign hr_a = mod_rem;
  assign nr_a = curi;
  assign fr_a = NW'(top_q - (NW+1)'(1));

  always_comb begin
    hw_en = 1'b0; hw_a = b_q; hw_d = NIL;
    kw_en = 1'b0; vw_en = 1'b0; nw_a = curi;
    lw_en = 1'b0; lw_a = curi; lw_d = NIL;
    fw_en = 1'b0; fw_a = sw_q[NW-1:0]; fw_d = sw_q[NW-1:0];
    case (st_q)
      StInit: begin
        hw_en = sw_q < SW'(MAX_BUCKETS);
        hw_a  = sw_q[BW-1:0];
        fw_en = sw_q < SW'(NODE_POOL);
      end
      StClear: begin
        hw_en = 1'b1;
        hw_a  = sw_q[BW-1:0];
        fw_en = sw_q < SW'(NODE_POOL);
      end
      StAct: begin
        if (cur_q != NIL && act_q == ActInsert) vw_en = 1'b1;
        if (cur_q != NIL && act_q == ActRemove) begin
          if (prev_q != NIL) begin
            lw_en = 1'b1; lw_a = prev_q[NW-1:0]; lw_d = nxt_q;
          end else begin
            hw_en = 1'b1; hw_d = nxt_q;
          end
          fw_en = top_q < (NW+1)'(NODE_POOL);
          fw_a  = top_q[NW-1:0];
          fw_d  = curi;
        end
      end
      StPopW: begin
        kw_en = 1'b1; vw_en = 1'b1; nw_a = free_rd;
        lw_en = 1'b1; lw_a = free_rd; lw_d = cur_q;
        hw_en = 1'b1; hw_d = {1'b0, free_rd};
      end
      default: ;
    endcase
  end

  assign mod_start = (st_q == StIdle) && start && action_i != ActClear;
  assign busy = st_q != StIdle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StInit;
      sw_q   <= '0;
      bc_q   <= 9'd256;
      top_q  <= (NW+1)'(NODE_POOL);
      tot_q  <= '0;
      done_o <= 1'b0;
      act_q  <= ActGet;
    end else begin
      done_o <= 1'b0;
      if (cfg_we_i) bc_q <= cfg_wdata_i;
      case (st_q)
        StInit, StClear: begin
          sw_q <= sw_q + SW'(1);
          if (sw_q == SW'((MAX_BUCKETS > NODE_POOL ? MAX_BUCKETS : NODE_POOL) - 1)) begin
            top_q <= (NW+1)'(NODE_POOL);
            tot_q <= '0;
            st_q  <= (st_q == StInit) ? StIdle : StOut;
          end
        end
        StIdle: begin
          res_q <= '0;
          if (start) begin
            act_q <= action_i;
            key_q <= key_i;
            val_q <= value_i;
            sw_q  <= '0;
            st_q  <= (action_i == ActClear) ? StClear : StMod;
          end
        end
        StMod: if (mod_done) begin
          b_q  <= mod_rem;
          st_q <= StHead;
        end
        StHead: st_q <= StHeadW;
        StHeadW: begin
          cur_q   <= head_rd;
          prev_q  <= NIL;
          steps_q <= '0;
          st_q    <= StNode;
        end
        StNode: st_q <= (cur_q == NIL || steps_q == (NW+1)'(NODE_POOL)) ? StAct : StNodeW;
        StNodeW: begin
          if (hit) begin
            nxt_q <= link_rd;
            st_q  <= StAct;
          end else begin
            prev_q  <= cur_q;
            cur_q   <= (link_rd > NIL) ? NIL : link_rd;
            steps_q <= steps_q + (NW+1)'(1);
            st_q    <= StNode;
          end
        end
        StAct: begin
          if (cur_q != NIL) begin
            res_q.found <= 1'b1;
            res_q.value <= val_rd;
            if (act_q == ActRemove) begin
              if (top_q < (NW+1)'(NODE_POOL)) top_q <= top_q + (NW+1)'(1);
              if (tot_q != '0) tot_q <= tot_q - (NW+1)'(1);
            end
            st_q <= StOut;
          end else if (act_q == ActInsert) begin
            if (top_q == '0) begin
              res_q.pool_full <= 1'b1;
              st_q <= StOut;
            end else begin
              cur_q <= NIL;
              st_q  <= StPop;
            end
          end else st_q <= StOut;
        end
        StPop: begin
          cur_q <= head_rd;
          st_q  <= StPopW;
        end
        StPopW: begin
          top_q <= top_q - (NW+1)'(1);
          tot_q <= tot_q + (NW+1)'(1);
          res_q.value <= val_q;
          st_q <= StOut;
        end
        StOut: begin
          done_o <= 1'b1;
          st_q   <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  assign found_o         = res_q.found;
  assign result_value_o  = res_q.value;
  assign element_count_o = 10'(tot_q);
  assign pool_full_o     = res_q.pool_full;

  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(found_o && pool_full_o))
    else $error("found and pool_full together");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tot_q + top_q <= (NW+1)'(NODE_POOL) || st_q == StInit || st_q == StClear)
    else $error("count and free stack disagree");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result held longer than one cycle");

endmodule
